### hdl/assert_macros.svh
// Assertion macros for the Bezier curve evaluator.
// Every macro expects signals named clock and reset in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BCE_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BCE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/bce_pkg.sv
// Shared widths, function codes and controller/datapath structs for the
// Bezier curve evaluator. Depends on nothing.
package bce_pkg;

   localparam int COORD_W        = 16;
   localparam int T_W            = 17;
   localparam int IDX_W          = 5;
   localparam int DEFAULT_DEGREE = 20;

   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_EVAL = 1'b1;

   localparam logic [T_W-1:0] T_ONE = 17'h10000;

   typedef struct packed {
      logic             start_eval;
      logic             load_we;
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
      logic             src_ctrl;
      logic             emit;
   } cmd_type;

   typedef struct packed {
      logic pipe_busy;
   } stat_type;

endpackage

### hdl/bce_channels.sv
// Valid/ready channel interfaces for the request and response sides.
// Depends on bce_pkg for the field widths.
interface bce_req_if;
   import bce_pkg::*;
   logic                      valid;
   logic                      ready;
   logic                      func;
   logic [IDX_W-1:0]          point_index;
   logic signed [COORD_W-1:0] point_x;
   logic signed [COORD_W-1:0] point_y;
   logic [T_W-1:0]            param_t;

   modport source (output valid, func, point_index, point_x, point_y, param_t,
                   input ready);
   modport sink (input valid, func, point_index, point_x, point_y, param_t,
                 output ready);
endinterface

interface bce_rsp_if;
   import bce_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] curve_x;
   logic signed [COORD_W-1:0] curve_y;
   logic                      was_clamped;

   modport source (output valid, curve_x, curve_y, was_clamped, input ready);
   modport sink (input valid, curve_x, curve_y, was_clamped, output ready);
endinterface

### hdl/bce_ram.sv
// Generic simple dual-port RAM with one write port and a registered read.
// Depends on nothing.
module bce_ram #(
   parameter int  WIDTH = 32,
   parameter int  DEPTH = 21,
   localparam int AddrW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/bce_datapath.sv
// Datapath: control point store, work store and the two-lane interpolation
// pipeline. Depends on bce_pkg and bce_ram.
module bce_datapath #(
   parameter int DEGREE = bce_pkg::DEFAULT_DEGREE
) (
   input  logic                               clock,
   input  logic                               reset,
   input  bce_pkg::cmd_type                   cmd,
   output bce_pkg::stat_type                  stat,
   input  logic [bce_pkg::IDX_W-1:0]          req_point_index,
   input  logic signed [bce_pkg::COORD_W-1:0] req_point_x,
   input  logic signed [bce_pkg::COORD_W-1:0] req_point_y,
   input  logic [bce_pkg::T_W-1:0]            req_param_t,
   output logic signed [bce_pkg::COORD_W-1:0] rsp_curve_x,
   output logic signed [bce_pkg::COORD_W-1:0] rsp_curve_y,
   output logic                               rsp_was_clamped
);
   import bce_pkg::*;

   localparam int AddrW  = $clog2(DEGREE + 1);
   localparam int DiffW  = COORD_W + 1;
   localparam int ProdW  = DiffW + T_W + 1;
   localparam int SumW   = COORD_W + 4;
   localparam int PairW  = 2 * COORD_W;

   logic [PairW-1:0] ctrl_rd;
   logic [PairW-1:0] work_rd;
   logic [PairW-1:0] work_wd;

   logic [T_W-1:0] t_ff;
   logic           clamp_ff;

   logic             vr_ff;
   logic [AddrW-1:0] jr_ff;
   logic             src_r_ff;

   logic                       v1_ff;
   logic [AddrW-1:0]           widx1_ff;
   logic signed [COORD_W-1:0]  a1_ff [2];
   logic signed [DiffW-1:0]    d1_ff [2];

   logic                       v2_ff;
   logic [AddrW-1:0]           widx2_ff;
   logic signed [COORD_W-1:0]  a2_ff [2];
   logic signed [ProdW-1:0]    p2_ff [2];

   logic signed [COORD_W-1:0]  prev_ff [2];
   logic signed [COORD_W-1:0]  last_ff [2];

   logic signed [COORD_W-1:0]  out_x_ff;
   logic signed [COORD_W-1:0]  out_y_ff;
   logic                       out_clamp_ff;

   logic signed [COORD_W-1:0]  b_c    [2];
   logic signed [DiffW-1:0]    diff_c [2];
   logic signed [ProdW-1:0]    prod_c [2];
   logic signed [ProdW-1:0]    rnd_c  [2];
   logic signed [SumW-1:0]     sum_c  [2];
   logic signed [COORD_W-1:0]  sat_c  [2];

   bce_ram #(.WIDTH(PairW), .DEPTH(DEGREE + 1)) u_ctrl_ram (
      .clock   (clock),
      .wr_en   (cmd.load_we),
      .wr_addr (req_point_index[AddrW-1:0]),
      .wr_data ({req_point_x, req_point_y}),
      .rd_en   (cmd.rd_en),
      .rd_addr (cmd.rd_addr[AddrW-1:0]),
      .rd_data (ctrl_rd)
   );

   bce_ram #(.WIDTH(PairW), .DEPTH(DEGREE + 1)) u_work_ram (
      .clock   (clock),
      .wr_en   (v2_ff),
      .wr_addr (widx2_ff),
      .wr_data (work_wd),
      .rd_en   (cmd.rd_en),
      .rd_addr (cmd.rd_addr[AddrW-1:0]),
      .rd_data (work_rd)
   );

   always_comb begin
      b_c[0] = src_r_ff ? $signed(ctrl_rd[PairW-1:COORD_W]) : $signed(work_rd[PairW-1:COORD_W]);
      b_c[1] = src_r_ff ? $signed(ctrl_rd[COORD_W-1:0]) : $signed(work_rd[COORD_W-1:0]);
      for (int k = 0; k < 2; k++) begin
         diff_c[k] = $signed({b_c[k][COORD_W-1], b_c[k]})
                   - $signed({prev_ff[k][COORD_W-1], prev_ff[k]});
         prod_c[k] = d1_ff[k] * $signed({1'b0, t_ff});
         rnd_c[k]  = p2_ff[k] + ProdW'(32768);
         sum_c[k]  = $signed({{(SumW - COORD_W){a2_ff[k][COORD_W-1]}}, a2_ff[k]})
                   + SumW'($signed(rnd_c[k][ProdW-1:16]));
         priority if (sum_c[k] > SumW'(32767)) begin
            sat_c[k] = 16'sh7FFF;
         end else if (sum_c[k] < -SumW'(32768)) begin
            sat_c[k] = 16'sh8000;
         end else begin
            sat_c[k] = sum_c[k][COORD_W-1:0];
         end
      end
   end

   assign work_wd = {sat_c[0], sat_c[1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         vr_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         vr_ff <= cmd.rd_en;
         v1_ff <= vr_ff && (jr_ff != '0);
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start_eval) begin
         t_ff     <= (req_param_t > T_ONE) ? T_ONE : req_param_t;
         clamp_ff <= req_param_t > T_ONE;
      end
      if (cmd.rd_en) begin
         jr_ff    <= cmd.rd_addr[AddrW-1:0];
         src_r_ff <= cmd.src_ctrl;
      end
      widx1_ff <= jr_ff - AddrW'(1);
      widx2_ff <= widx1_ff;
      for (int k = 0; k < 2; k++) begin
         if (vr_ff) begin
            prev_ff[k] <= b_c[k];
         end
         a1_ff[k] <= prev_ff[k];
         d1_ff[k] <= diff_c[k];
         a2_ff[k] <= a1_ff[k];
         p2_ff[k] <= prod_c[k];
         if (v2_ff) begin
            last_ff[k] <= sat_c[k];
         end
      end
      if (cmd.emit) begin
         out_x_ff     <= last_ff[0];
         out_y_ff     <= last_ff[1];
         out_clamp_ff <= clamp_ff;
      end
   end

   assign stat.pipe_busy  = vr_ff | v1_ff | v2_ff;
   assign rsp_curve_x     = out_x_ff;
   assign rsp_curve_y     = out_y_ff;
   assign rsp_was_clamped = out_clamp_ff;

endmodule

### hdl/bce_ctrl.sv
// Controller: accepts load and evaluate beats and sequences the levels and
// reads of the de Casteljau sweep. Depends on bce_pkg.
module bce_ctrl #(
   parameter int DEGREE = bce_pkg::DEFAULT_DEGREE
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_func,
   input  logic [bce_pkg::IDX_W-1:0] req_point_index,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output bce_pkg::cmd_type          cmd,
   input  bce_pkg::stat_type         stat
);
   import bce_pkg::*;

   localparam int AddrW = $clog2(DEGREE + 1);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_RUN    = 2'd1;
   localparam logic [1:0] ST_DRAIN  = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [AddrW-1:0] lvl_ff, lvl_in;
   logic [AddrW-1:0] idx_ff, idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      lvl_in   = lvl_ff;
      idx_in   = idx_ff;
      cmd      = '0;
      cmd.rd_addr  = IDX_W'(idx_ff);
      cmd.src_ctrl = (lvl_ff == AddrW'(DEGREE));
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_func == FUNC_EVAL) begin
                  cmd.start_eval = 1'b1;
                  lvl_in   = AddrW'(DEGREE);
                  idx_in   = '0;
                  state_in = ST_RUN;
               end else begin
                  cmd.load_we = ({1'b0, req_point_index} <= (IDX_W + 1)'(DEGREE));
               end
            end
         end
         ST_RUN: begin
            cmd.rd_en = 1'b1;
            if (idx_ff == lvl_ff) begin
               state_in = ST_DRAIN;
            end else begin
               idx_in = idx_ff + AddrW'(1);
            end
         end
         ST_DRAIN: begin
            if (!stat.pipe_busy) begin
               if (lvl_ff == AddrW'(1)) begin
                  state_in = ST_FINISH;
               end else begin
                  lvl_in   = lvl_ff - AddrW'(1);
                  idx_in   = '0;
                  state_in = ST_RUN;
               end
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lvl_ff <= lvl_in;
      idx_ff <= idx_in;
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### hdl/bezier_curve_evaluator.sv
// Bezier curve evaluator by de Casteljau with two interpolation lanes (x and y).
// An evaluate beat sweeps the levels from DEGREE down to 1, reading each point
// of a level (the control RAM at the top level, the work RAM below) and letting
// the pipeline drain before it starts the next level.
// One item is worked at a time. Synchronous active-high reset clears control
// state only; the point stores hold no defined value until loaded.
`include "assert_macros.svh"

module bezier_curve_evaluator #(
   parameter int DEGREE = bce_pkg::DEFAULT_DEGREE
) (
   input logic      clock,
   input logic      reset,
   bce_req_if.sink  req_bus,
   bce_rsp_if.source rsp_bus
);
   import bce_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   bce_ctrl #(.DEGREE(DEGREE)) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_bus.valid),
      .req_ready       (req_bus.ready),
      .req_func        (req_bus.func),
      .req_point_index (req_bus.point_index),
      .rsp_valid       (rsp_bus.valid),
      .rsp_ready       (rsp_bus.ready),
      .cmd             (cmd),
      .stat            (stat)
   );

   bce_datapath #(.DEGREE(DEGREE)) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_point_index (req_bus.point_index),
      .req_point_x     (req_bus.point_x),
      .req_point_y     (req_bus.point_y),
      .req_param_t     (req_bus.param_t),
      .rsp_curve_x     (rsp_bus.curve_x),
      .rsp_curve_y     (rsp_bus.curve_y),
      .rsp_was_clamped (rsp_bus.was_clamped)
   );

   `BCE_ASSERT_SAME(a_emit_drained, cmd.emit, !stat.pipe_busy, "Result taken before the pipeline drained.")
   `BCE_ASSERT_NEXT(a_eval_starts, req_bus.valid && req_bus.ready && (req_bus.func == FUNC_EVAL), cmd.rd_en, "Evaluate beat did not start the sweep.")
   `BCE_ASSERT_NEXT(a_emit_shows, cmd.emit, rsp_bus.valid, "Emitted result is not presented.")

endmodule

### tb/bezier_curve_evaluator_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the degree-20 Bezier curve evaluator: control point loads,
// curve evaluations and clamped parameters under several idle and stall patterns.
// Depends on bce_pkg, the channel interfaces in bce_channels.sv and the evaluator RTL.
module bezier_curve_evaluator_test;
   import bce_pkg::*;

   localparam int DEGREE = DEFAULT_DEGREE;
   localparam int NUM_POINTS = DEGREE + 1;
   localparam int EVAL_CYCLES = DEGREE * (DEGREE + 1) / 2 + 5 * DEGREE + 2;
   localparam int CYCLE_LIMIT = 3_000_000;
   localparam int LONG_STALL_CYCLES = 3 * EVAL_CYCLES;
   localparam logic signed [COORD_W-1:0] COORD_MIN = COORD_W'(-(2 ** (COORD_W - 1)));
   localparam logic signed [COORD_W-1:0] COORD_MAX = COORD_W'(2 ** (COORD_W - 1) - 1);
   localparam logic [T_W-1:0] T_MAX = T_W'(2 ** T_W - 1);

   typedef struct packed {
      logic                      func;
      logic [IDX_W-1:0]          index;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic [T_W-1:0]            t;
   } curve_req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic                      clamped;
   } curve_point_type;

   logic clock;
   logic reset;

   bce_req_if req_bus();
   bce_rsp_if rsp_bus();

   bezier_curve_evaluator #(.DEGREE(DEGREE)) uut (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   logic signed [COORD_W-1:0] ctrl_x [NUM_POINTS];
   logic signed [COORD_W-1:0] ctrl_y [NUM_POINTS];
   curve_point_type expected_points [$];
   int error_count = 0;
   int cycle_count = 0;
   int src_idle_pct = 0;
   int sink_stall_pct = 0;
   int long_stall_left = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic signed [COORD_W-1:0] lerp_fixed(
      input logic signed [COORD_W-1:0] a,
      input logic signed [COORD_W-1:0] b,
      input logic [T_W-1:0] t
   );
      longint prod;
      longint sum;
      prod = (longint'(b) - longint'(a)) * longint'(t);
      sum = longint'(a) + ((prod + 32768) >>> 16);
      if (sum < longint'(COORD_MIN)) return COORD_MIN;
      if (sum > longint'(COORD_MAX)) return COORD_MAX;
      return sum[COORD_W-1:0];
   endfunction

   function automatic curve_point_type curve_at(input logic [T_W-1:0] t_in);
      logic signed [COORD_W-1:0] wx [NUM_POINTS];
      logic signed [COORD_W-1:0] wy [NUM_POINTS];
      logic [T_W-1:0] t;
      curve_point_type pt;
      pt.clamped = (t_in > T_ONE);
      t = pt.clamped ? T_ONE : t_in;
      for (int i = 0; i < NUM_POINTS; i++) begin
         wx[i] = ctrl_x[i];
         wy[i] = ctrl_y[i];
      end
      for (int lvl = DEGREE; lvl > 0; lvl--) begin
         for (int i = 0; i < lvl; i++) begin
            wx[i] = lerp_fixed(wx[i], wx[i + 1], t);
            wy[i] = lerp_fixed(wy[i], wy[i + 1], t);
         end
      end
      pt.x = wx[0];
      pt.y = wy[0];
      return pt;
   endfunction

   function automatic logic signed [COORD_W-1:0] random_coord();
      case ($urandom_range(7))
         0: return COORD_MIN;
         1: return COORD_MAX;
         default: return COORD_W'($urandom);
      endcase
   endfunction

   function automatic logic [T_W-1:0] random_t();
      case ($urandom_range(9))
         0: return $urandom_range(1) ? T_ONE : '0;
         1: return T_W'($urandom_range(T_MAX, T_ONE + 1));
         2: return T_W'($urandom_range(3));
         3: return T_W'(T_ONE - $urandom_range(3));
         default: return T_W'($urandom_range(T_ONE));
      endcase
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("ERROR cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
      error_count++;
   endtask

   task automatic track_beat(input curve_req_type beat);
      if (beat.func == FUNC_LOAD) begin
         if (beat.index < NUM_POINTS) begin
            ctrl_x[beat.index] = beat.x;
            ctrl_y[beat.index] = beat.y;
         end
      end else begin
         expected_points.push_back(curve_at(beat.t));
      end
   endtask

   task automatic send_beat(input curve_req_type beat);
      if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
         req_bus.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < src_idle_pct);
      end
      req_bus.valid <= 1'b1;
      req_bus.func <= beat.func;
      req_bus.point_index <= beat.index;
      req_bus.point_x <= beat.x;
      req_bus.point_y <= beat.y;
      req_bus.param_t <= beat.t;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      track_beat(beat);
   endtask

   task automatic send_load(input int index, input logic signed [COORD_W-1:0] x,
                            input logic signed [COORD_W-1:0] y);
      curve_req_type beat;
      beat.func = FUNC_LOAD;
      beat.index = IDX_W'(index);
      beat.x = x;
      beat.y = y;
      beat.t = T_W'($urandom);
      send_beat(beat);
   endtask

   task automatic send_eval(input logic [T_W-1:0] t);
      curve_req_type beat;
      beat.func = FUNC_EVAL;
      beat.index = IDX_W'($urandom);
      beat.x = COORD_W'($urandom);
      beat.y = COORD_W'($urandom);
      beat.t = t;
      send_beat(beat);
   endtask

   task automatic send_random_beat(output bit counted);
      int pick;
      pick = $urandom_range(99);
      counted = 1'b1;
      if (pick < 45) begin
         send_eval(random_t());
      end else if (pick < 50) begin
         send_load($urandom_range(31, NUM_POINTS), random_coord(), random_coord());
         counted = 1'b0;
      end else begin
         send_load($urandom_range(DEGREE), random_coord(), random_coord());
      end
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (expected_points.size() != 0);
   endtask

   task automatic test_directed_extremes();
      src_idle_pct = 0;
      sink_stall_pct = 0;
      for (int i = 0; i < NUM_POINTS; i++) begin
         send_load(i, (i % 2) ? COORD_MAX : COORD_MIN, (i % 2) ? COORD_MIN : COORD_MAX);
      end
      send_load(NUM_POINTS, '0, '0);
      send_load(31, COORD_MAX, COORD_MIN);
      send_eval('0);
      send_eval(T_W'(1));
      send_eval(T_W'(T_ONE / 2));
      send_eval(T_W'(T_ONE - 1));
      send_eval(T_ONE);
      send_eval(T_W'(T_ONE + 1));
      send_eval(T_MAX);
      wait_drained();
   endtask

   task automatic test_random_traffic(input int beats, input int src_pct, input int sink_pct);
      bit counted;
      int sent;
      src_idle_pct = src_pct;
      sink_stall_pct = sink_pct;
      sent = 0;
      while (sent < beats) begin
         send_random_beat(counted);
         if (counted) sent++;
      end
      wait_drained();
   endtask

   task automatic test_output_holdoff();
      bit counted;
      src_idle_pct = 0;
      sink_stall_pct = 0;
      long_stall_left <= LONG_STALL_CYCLES;
      send_eval(random_t());
      send_eval(random_t());
      for (int i = 0; i < 6; i++) send_random_beat(counted);
      wait_drained();
   endtask

   always @(posedge clock) begin
      if (long_stall_left != 0) begin
         rsp_bus.ready <= 1'b0;
         long_stall_left <= long_stall_left - 1;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
   end

   always @(posedge clock) begin
      curve_point_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (expected_points.size() == 0) begin
            report_mismatch("response beat with nothing pending, curve_x", rsp_bus.curve_x, 0);
         end else begin
            want = expected_points.pop_front();
            if (rsp_bus.curve_x !== want.x) report_mismatch("curve_x", rsp_bus.curve_x, want.x);
            if (rsp_bus.curve_y !== want.y) report_mismatch("curve_y", rsp_bus.curve_y, want.y);
            if (rsp_bus.was_clamped !== want.clamped) begin
               report_mismatch("was_clamped", rsp_bus.was_clamped, want.clamped);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.func = FUNC_LOAD;
      req_bus.point_index = '0;
      req_bus.point_x = '0;
      req_bus.point_y = '0;
      req_bus.param_t = '0;
      rsp_bus.ready = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_extremes();
      test_output_holdoff();
      test_random_traffic(410, 0, 0);
      test_random_traffic(410, 58, 0);
      test_random_traffic(410, 0, 58);
      test_random_traffic(410, 31, 31);
      repeat (EVAL_CYCLES + 50) @(posedge clock);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+hdl
hdl/bce_pkg.sv
hdl/bce_channels.sv
hdl/bce_ram.sv
hdl/bce_datapath.sv
hdl/bce_ctrl.sv
hdl/bezier_curve_evaluator.sv
tb/bezier_curve_evaluator_test.sv
